/* rtl/core/ledmx_pkg.sv */
// Shared types, codes and microcode table for the LED matrix display interface.
// No dependencies; imported by led_matrix_display_interface.
package ledmx_pkg;

    localparam int STORE_BYTES = 16;
    localparam int IDX_W       = $clog2(STORE_BYTES);

    localparam logic [2:0] OP_WRITE   = 3'd0;
    localparam logic [2:0] OP_CLEAR   = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_BRIGHT  = 3'd3;
    localparam logic [2:0] OP_INIT    = 3'd4;

    localparam logic [7:0] CMD_MODE      = 8'h40;
    localparam logic [7:0] CMD_DISPLAY   = 8'h80;
    localparam logic [7:0] CMD_ADDRESS   = 8'hC0;
    localparam logic [3:0] DISPLAY_ON    = 4'h8;
    localparam logic [3:0] DISPLAY_FIELD = 4'hF;
    localparam logic [7:0] CMD_DISP_MAX  = 8'h8F;

    localparam logic [1:0] SRC_CONST  = 2'd0;
    localparam logic [1:0] SRC_STORE  = 2'd1;
    localparam logic [1:0] SRC_BRIGHT = 2'd2;

    localparam logic [2:0] PC_IDLE     = 3'd0;
    localparam logic [2:0] PC_ADDR_CMD = 3'd1;
    localparam logic [2:0] PC_STORE    = 3'd2;
    localparam logic [2:0] PC_BRIGHT   = 3'd3;
    localparam logic [2:0] PC_MODE     = 3'd4;
    localparam logic [2:0] PC_DISP_ON  = 3'd5;

    typedef struct packed {
        logic [1:0] src;
        logic [7:0] konst;
        logic       fs;
        logic       fe;
        logic       lst;
        logic       loop_idx;
        logic [2:0] next;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [2:0] pc);
        ctrl_t c;
        c = '{src: SRC_CONST, konst: 8'h00, fs: 1'b0, fe: 1'b0, lst: 1'b0,
              loop_idx: 1'b0, next: PC_IDLE};
        unique case (pc)
            PC_ADDR_CMD: begin
                c.konst = CMD_ADDRESS;
                c.fs    = 1'b1;
                c.next  = PC_STORE;
            end
            PC_STORE: begin
                c.src      = SRC_STORE;
                c.loop_idx = 1'b1;
            end
            PC_BRIGHT: begin
                c.src = SRC_BRIGHT;
                c.fs  = 1'b1;
                c.fe  = 1'b1;
                c.lst = 1'b1;
            end
            PC_MODE: begin
                c.konst = CMD_MODE;
                c.fs    = 1'b1;
                c.fe    = 1'b1;
                c.next  = PC_DISP_ON;
            end
            PC_DISP_ON: begin
                c.konst = CMD_DISP_MAX;
                c.fs    = 1'b1;
                c.fe    = 1'b1;
                c.lst   = 1'b1;
            end
            default: begin
                c.next = PC_IDLE;
            end
        endcase
        return c;
    endfunction

    function automatic logic [2:0] dispatch(input logic [2:0] op);
        logic [2:0] pc;
        unique case (op)
            OP_REFRESH: pc = PC_ADDR_CMD;
            OP_BRIGHT:  pc = PC_BRIGHT;
            OP_INIT:    pc = PC_MODE;
            default:    pc = PC_IDLE;
        endcase
        return pc;
    endfunction

    function automatic logic [7:0] bright_byte(input logic [3:0] level);
        logic [3:0] ctrl;
        ctrl = (level == 4'd0) ? 4'd0 : ((DISPLAY_ON | (level - 4'd1)) & DISPLAY_FIELD);
        return CMD_DISPLAY | {4'd0, ctrl};
    endfunction

endpackage

/* rtl/core/led_matrix_display_interface.sv */
// The first output byte is registered from the microcode step the request selects.
// Refresh sends 17 bytes (address command + 16 store bytes), init 2, brightness 1,
// write/clear/unused ops none; one byte per cycle while m_ready stays high.
// Rate is set by the microcode sequencer emitting one byte per step.
// Reset (aresetn low, synchronous) zeroes the store, selects common cathode,
// returns the sequencer to idle and drops m_valid.
module led_matrix_display_interface
    import ledmx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    input  logic [3:0] s_address,
    input  logic [7:0] s_data,
    input  logic [3:0] s_level,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_frame_start,
    output logic       m_frame_end,
    output logic       m_last
);

    logic [7:0]       store_reg [STORE_BYTES];
    logic             anode_reg;
    logic [2:0]       pc_reg, pc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]       level_reg;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       byte_reg;
    logic             fs_reg, fe_reg, lst_reg;

    ctrl_t      ctrl;
    logic       accept;
    logic       out_free;
    logic       load;
    logic       idx_last;
    logic [7:0] src_byte;

    assign cfg_ready = 1'b1;
    assign s_ready   = (pc_reg == PC_IDLE);
    assign accept    = s_valid && s_ready;
    assign ctrl      = ucode(pc_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign load      = (pc_reg != PC_IDLE) && out_free;
    assign idx_last  = (idx_reg == IDX_W'(STORE_BYTES - 1));

    always_comb begin
        unique case (ctrl.src)
            SRC_STORE:  src_byte = store_reg[idx_reg];
            SRC_BRIGHT: src_byte = bright_byte(level_reg);
            default:    src_byte = ctrl.konst;
        endcase
    end

    always_comb begin
        pc_next      = pc_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            pc_next  = dispatch(s_op);
            idx_next = '0;
        end else if (load) begin
            m_valid_next = 1'b1;
            if (ctrl.loop_idx) begin
                idx_next = idx_reg + 1'b1;
                pc_next  = idx_last ? ctrl.next : pc_reg;
            end else begin
                pc_next = ctrl.next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= PC_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            anode_reg   <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                anode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            level_reg <= s_level;
        end
        if (load) begin
            byte_reg <= src_byte;
            fs_reg   <= ctrl.fs;
            fe_reg   <= ctrl.loop_idx ? idx_last : ctrl.fe;
            lst_reg  <= ctrl.loop_idx ? idx_last : ctrl.lst;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < STORE_BYTES; e++) begin
                store_reg[e] <= 8'd0;
            end
        end else if (accept && s_op == OP_CLEAR) begin
            for (int e = 0; e < STORE_BYTES; e++) begin
                store_reg[e] <= 8'd0;
            end
        end else if (accept && s_op == OP_WRITE) begin
            if (!anode_reg) begin
                store_reg[s_address] <= s_data;
            end else begin
                for (int i = 0; i < 8; i++) begin
                    store_reg[{i[2:0], s_address[3]}][s_address[2:0]] <= s_data[i];
                end
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_frame_start = fs_reg;
    assign m_frame_end   = fe_reg;
    assign m_last        = lst_reg;

    a_refresh_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == OP_REFRESH) |=> (pc_reg == PC_ADDR_CMD && idx_reg == '0))
        else $error("refresh did not enter address command step");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && (ctrl.loop_idx ? idx_last : ctrl.lst)) |=> (pc_reg == PC_IDLE))
        else $error("sequencer kept running after final byte");

    a_last_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> m_frame_end)
        else $error("final byte without strobe release");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == OP_CLEAR) |=> (store_reg[0] == 8'd0 && store_reg[STORE_BYTES-1] == 8'd0))
        else $error("clear left store data behind");

endmodule
